// ===== rtl/core/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types, character codes and register map of the text console cursor
// engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // character codes with a control meaning
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [8:0]  TAB_STEP = 9'd8;
    localparam logic [23:0] WHITE    = 24'hFFFFFF;
    localparam logic [12:0] PIX_MAX  = 13'h1FFF;

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // register map, index = paddr[4:2]
    localparam int         ADDR_W      = 5;
    localparam logic [2:0] REG_LEFT    = 3'd0;
    localparam logic [2:0] REG_RIGHT   = 3'd1;
    localparam logic [2:0] REG_TOP     = 3'd2;
    localparam logic [2:0] REG_BOTTOM  = 3'd3;
    localparam logic [2:0] REG_GWIDTH  = 3'd4;
    localparam logic [2:0] REG_GHEIGHT = 3'd5;
    localparam logic [2:0] REG_MODE    = 3'd6;
    localparam logic [2:0] REG_INK     = 3'd7;

    localparam logic [7:0]  RST_LEFT    = 8'd0;
    localparam logic [7:0]  RST_RIGHT   = 8'd80;
    localparam logic [7:0]  RST_TOP     = 8'd0;
    localparam logic [7:0]  RST_BOTTOM  = 8'd25;
    localparam logic [5:0]  RST_GWIDTH  = 6'd8;
    localparam logic [5:0]  RST_GHEIGHT = 6'd8;
    localparam logic [1:0]  RST_MODE    = 2'd0;
    localparam logic [23:0] RST_INK     = 24'hFFFFFF;

    typedef struct packed {
        logic [7:0]  left_col;
        logic [7:0]  right_col;
        logic [7:0]  top_row;
        logic [7:0]  bottom_row;
        logic [5:0]  glyph_width;
        logic [5:0]  glyph_height;
        logic [1:0]  mode_flags;
        logic [23:0] ink_color;
    } t_cfg;

    // one classified item: an optional scroll, then an optional draw
    typedef struct packed {
        logic       has_scroll;
        logic       has_draw;
        logic [7:0] glyph;
        logic [7:0] col;
        logic [7:0] row;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] less_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd0 : v - 8'd1;
    endfunction

endpackage

// ===== rtl/core/tcce_regs.sv =====
// ----------------------------------------------------------------------------
// tcce_regs
// APB-style configuration registers of the cursor engine.
// ----------------------------------------------------------------------------
module tcce_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcce_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output tcce_pkg::t_cfg              o_cfg
);
    import tcce_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = paddr[4:2];
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_col     <= RST_LEFT;
            r_cfg.right_col    <= RST_RIGHT;
            r_cfg.top_row      <= RST_TOP;
            r_cfg.bottom_row   <= RST_BOTTOM;
            r_cfg.glyph_width  <= RST_GWIDTH;
            r_cfg.glyph_height <= RST_GHEIGHT;
            r_cfg.mode_flags   <= RST_MODE;
            r_cfg.ink_color    <= RST_INK;
        end else if (wr_en) begin
            case (idx)
                REG_LEFT:    r_cfg.left_col     <= pwdata[7:0];
                REG_RIGHT:   r_cfg.right_col    <= pwdata[7:0];
                REG_TOP:     r_cfg.top_row      <= pwdata[7:0];
                REG_BOTTOM:  r_cfg.bottom_row   <= pwdata[7:0];
                REG_GWIDTH:  r_cfg.glyph_width  <= pwdata[5:0];
                REG_GHEIGHT: r_cfg.glyph_height <= pwdata[5:0];
                REG_MODE:    r_cfg.mode_flags   <= pwdata[1:0];
                REG_INK:     r_cfg.ink_color    <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_LEFT:    prdata = {24'd0, r_cfg.left_col};
            REG_RIGHT:   prdata = {24'd0, r_cfg.right_col};
            REG_TOP:     prdata = {24'd0, r_cfg.top_row};
            REG_BOTTOM:  prdata = {24'd0, r_cfg.bottom_row};
            REG_GWIDTH:  prdata = {26'd0, r_cfg.glyph_width};
            REG_GHEIGHT: prdata = {26'd0, r_cfg.glyph_height};
            REG_MODE:    prdata = {30'd0, r_cfg.mode_flags};
            REG_INK:     prdata = {8'd0, r_cfg.ink_color};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/core/tcce_front.sv =====
// ----------------------------------------------------------------------------
// tcce_front
// Accepts character items, keeps the cursor and the previous character, and
// pushes a scroll/draw command for every item that causes a result.
// ----------------------------------------------------------------------------
module tcce_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcce_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_char_code,
    input  tcce_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output tcce_pkg::t_cmd    o_cmd
);
    import tcce_pkg::*;

    logic [7:0] r_col, n_col;
    logic [7:0] r_row, n_row;
    logic [7:0] r_prev, n_prev;
    logic [7:0] rlim, blim;
    logic [8:0] tab_sum;
    logic [8:0] row_inc;
    logic [7:0] row_adv;
    logic       accept;
    t_cmd       cmd;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;
    assign rlim    = less_one(i_cfg.right_col);
    assign blim    = less_one(i_cfg.bottom_row);
    assign tab_sum = {1'b0, r_col} + TAB_STEP;
    assign row_inc = {1'b0, r_row} + 9'd1;

    always_comb begin
        n_col          = r_col;
        n_row          = r_row;
        n_prev         = i_char_code;
        row_adv        = r_row;
        cmd.has_scroll = 1'b0;
        cmd.has_draw   = 1'b0;
        cmd.glyph      = i_char_code;
        case (i_char_code)
            CH_FF: begin
                n_row  = i_cfg.top_row;
                n_col  = i_cfg.left_col;
                n_prev = r_prev;
            end
            CH_LF: begin
                if (r_row >= blim) begin
                    cmd.has_scroll = 1'b1;
                    n_row = blim;
                    n_col = i_cfg.left_col;
                end else begin
                    n_row = row_inc[7:0];
                    if (r_prev == CH_CR || i_cfg.mode_flags != 2'd0) begin
                        n_col = i_cfg.left_col;
                    end
                end
            end
            CH_TAB: begin
                n_col = (tab_sum > {1'b0, rlim}) ? rlim : tab_sum[7:0];
            end
            CH_CR: begin
                n_col = i_cfg.left_col;
            end
            CH_BS: begin
                n_col = (r_col > i_cfg.left_col) ? r_col - 8'd1 : i_cfg.left_col;
            end
            default: begin
                // advance, or wrap to the next row saturating at the last row
                if (r_col >= rlim) begin
                    n_col   = i_cfg.left_col;
                    row_adv = row_inc[8] ? 8'hFF : row_inc[7:0];
                end else begin
                    n_col = r_col + 8'd1;
                end
                n_row = row_adv;
                if (row_adv >= i_cfg.bottom_row) begin
                    cmd.has_scroll = 1'b1;
                    n_row = blim;
                    n_col = i_cfg.left_col;
                end
                cmd.has_draw = 1'b1;
            end
        endcase
        cmd.col = n_col;
        cmd.row = n_row;
    end

    assign o_push = accept && (cmd.has_scroll || cmd.has_draw);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= 8'd0;
            r_row  <= 8'd0;
            r_prev <= 8'd0;
        end else if (accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_prev <= n_prev;
        end
    end

endmodule

// ===== rtl/core/tcce_queue.sv =====
// ----------------------------------------------------------------------------
// tcce_queue
// Short command queue between the front and the back of the cursor engine.
// ----------------------------------------------------------------------------
module tcce_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tcce_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output tcce_pkg::t_cmd    o_head,
    output tcce_pkg::t_q_stat o_stat
);
    import tcce_pkg::*;

    t_cmd          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr, r_rptr;
    logic [Q_AW:0]   r_count;
    logic            do_push, do_pop;

    assign o_stat.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + Q_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (Q_AW+1)'(1);
                2'b01:   r_count <= r_count - (Q_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/tcce_back.sv =====
// ----------------------------------------------------------------------------
// tcce_back
// Turns queued commands into scroll and draw result items, one per cycle while
// the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module tcce_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcce_pkg::t_cfg    i_cfg,
    input  tcce_pkg::t_cmd    i_head,
    input  tcce_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_kind,
    output logic [12:0]       o_pixel_x,
    output logic [12:0]       o_pixel_y,
    output logic [7:0]        o_glyph,
    output logic [23:0]       o_color,
    output logic              o_transparent,
    output logic              o_last
);
    import tcce_pkg::*;

    logic        r_valid;
    logic        r_phase, n_phase;
    logic        r_kind, n_kind;
    logic [12:0] r_px, n_px;
    logic [12:0] r_py, n_py;
    logic [7:0]  r_glyph, n_glyph;
    logic [23:0] r_color, n_color;
    logic        r_transp, n_transp;
    logic        r_last, n_last;
    logic        load;
    logic        term;
    logic [13:0] draw_x, draw_y, scroll_y;

    assign term     = i_cfg.mode_flags[0];
    assign load     = !i_q_stat.empty && (!r_valid || i_ready);
    assign draw_x   = {6'd0, i_head.col} * {8'd0, i_cfg.glyph_width};
    assign draw_y   = {6'd0, i_head.row} * {8'd0, i_cfg.glyph_height};
    assign scroll_y = {6'd0, less_one(i_cfg.bottom_row)} * {8'd0, i_cfg.glyph_height};

    always_comb begin
        n_color  = term ? WHITE : i_cfg.ink_color;
        n_transp = !term;
        if (i_head.has_scroll && !r_phase) begin
            // scroll first; hold the command when a draw follows
            n_kind  = 1'b1;
            n_px    = 13'd0;
            n_py    = scroll_y[13] ? PIX_MAX : scroll_y[12:0];
            n_glyph = CH_SPACE;
            n_last  = !i_head.has_draw;
            n_phase = i_head.has_draw;
            o_pop   = load && !i_head.has_draw;
        end else begin
            n_kind  = 1'b0;
            n_px    = draw_x[13] ? PIX_MAX : draw_x[12:0];
            n_py    = draw_y[13] ? PIX_MAX : draw_y[12:0];
            n_glyph = i_head.glyph;
            n_last  = 1'b1;
            n_phase = 1'b0;
            o_pop   = load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= n_phase;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= n_kind;
            r_px     <= n_px;
            r_py     <= n_py;
            r_glyph  <= n_glyph;
            r_color  <= n_color;
            r_transp <= n_transp;
            r_last   <= n_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_glyph       = r_glyph;
    assign o_color       = r_color;
    assign o_transparent = r_transp;
    assign o_last        = r_last;

endmodule

// ===== rtl/core/text_console_cursor_engine.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Cursor control for a pixel text console: character items in, scroll and
// draw result items out, registers on an APB-style port.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     i_valid / o_ready    i_char_code
//  output    o_valid / i_ready    o_kind o_pixel_x o_pixel_y o_glyph
//                                 o_color o_transparent o_last
//  config    psel penable pwrite  paddr pwdata prdata (pready tied high)
//
//  One input item per cycle while the queue is not full; the front's cursor
//  update is combinational. The back delivers one result item per cycle while
//  i_ready is high, so an item with a scroll and a draw gives the scroll, then
//  the draw. Commands pass through the queue, then the output register. A
//  four-entry command queue decouples the sides: input stalls only when it is
//  full. Synchronous active-low reset clears cursor, queue and registers.
// ----------------------------------------------------------------------------
module text_console_cursor_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_char_code,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_kind,
    output logic [12:0]                 o_pixel_x,
    output logic [12:0]                 o_pixel_y,
    output logic [7:0]                  o_glyph,
    output logic [23:0]                 o_color,
    output logic                        o_transparent,
    output logic                        o_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcce_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import tcce_pkg::*;

    t_cfg    cfg;
    t_cmd    push_cmd, head_cmd;
    t_q_stat q_stat;
    logic    push, pop;

    assign pready = 1'b1;

    tcce_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    tcce_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    tcce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (q_stat)
    );

    tcce_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_head        (head_cmd),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_glyph       (o_glyph),
        .o_color       (o_color),
        .o_transparent (o_transparent),
        .o_last        (o_last)
    );

endmodule

// ===== rtl/core/tcce_checker.sv =====
// ----------------------------------------------------------------------------
// tcce_checker
// Port-level checks of the cursor engine, bound to the top level.
// ----------------------------------------------------------------------------
module tcce_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_kind,
    input logic [12:0] o_pixel_x,
    input logic [7:0]  o_glyph,
    input logic [23:0] o_color,
    input logic        o_transparent,
    input logic        o_last
);
    import tcce_pkg::*;

    // a stalled result item holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable({o_kind, o_pixel_x, o_glyph, o_last}))
        else $error("stalled result item changed");

    // draw is always the final result of its item
    a_draw_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_kind |-> o_last)
        else $error("draw result not marked last");

    a_scroll_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> o_pixel_x == 13'd0 && o_glyph == CH_SPACE)
        else $error("scroll result malformed");

    a_opaque_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_transparent |-> o_color == WHITE)
        else $error("opaque result not white");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_kind        (o_kind),
    .o_pixel_x     (o_pixel_x),
    .o_glyph       (o_glyph),
    .o_color       (o_color),
    .o_transparent (o_transparent),
    .o_last        (o_last)
);
